[rtl/pba_pkg.sv]
// Shared constants and a saturating increment for the power-of-two block allocator.
// No dependencies; imported by the allocator and its port checker.
package pba_pkg;

    localparam int CNT_W   = 32;
    localparam int ORDER_W = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Saturating increment for free counts and the grant total.
    function automatic logic [CNT_W-1:0] cnt_sat_inc(input logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
    endfunction

endpackage

[rtl/power_of_two_block_allocator.sv]
// Power-of-two block allocator: per-order free counts in a small memory,
// walked one order at a time by a sequencer. Depends on pba_pkg.
//
// Usage
//   Input words arrive on s_t*. s_tuser is the kind: 0 hands a free region
//   to the allocator (s_tdata region_size), 1 requests one block of order
//   block_order. Each input word yields exactly one result word on m_t*:
//   m_tuser is the grant flag, m_tdata the saturating count of grants.
//   Sequencing
//   One item at a time; s_tready is high only while the sequencer is idle.
//   The free counts sit in a single-port-write, registered-read memory, and
//   the sequencer touches one order per step: a region word walks the low
//   min(LEVELS,SIZE_BITS) orders, a request scans upward from block_order
//   and then splits back down one order at a time.
//   Reset clears all free counts (per-entry valid flags) and the grant count
//   at once; no clearing pass. If the receiver stalls, the finished result
//   waits in the output register and the next item is still taken; the
//   sequencer only holds once a second result is ready.
module power_of_two_block_allocator
    import pba_pkg::*;
#(
    parameter int LEVELS    = 40,
    parameter int SIZE_BITS = 34,
    localparam int S_DATA_W = ((SIZE_BITS + ORDER_W + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // region_size, block_order, zero pad
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CNT_W-1:0]    m_tdata,   // total_granted
    output logic                m_tuser    // granted
);

    localparam int LW    = $clog2(LEVELS);
    localparam int IDX_W = LW + 1;
    localparam int NADD  = (LEVELS < SIZE_BITS) ? LEVELS : SIZE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     order_reg, order_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 granted_reg, granted_next;
    logic [CNT_W-1:0]     grant_total_reg, grant_total_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // free count memory, registered read
    logic [CNT_W-1:0]     mem [0:LEVELS-1];
    logic [LEVELS-1:0]    valid_reg;
    logic [CNT_W-1:0]     rdata_reg;
    logic                 rvalid_reg;
    logic                 mem_we;
    logic [CNT_W-1:0]     mem_wdata;
    logic [LW-1:0]        mem_addr;
    logic [CNT_W-1:0]     cnt;

    logic [ORDER_W-1:0]   in_order;
    logic                 order_ok;

    assign mem_addr = idx_reg[LW-1:0];
    assign cnt      = rvalid_reg ? rdata_reg : '0;
    assign in_order = s_tdata[SIZE_BITS +: ORDER_W];
    assign order_ok = {1'b0, in_order} < (ORDER_W+1)'(LEVELS);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        order_next       = order_reg;
        size_next        = size_reg;
        granted_next     = granted_reg;
        grant_total_next = grant_total_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        mem_we           = 1'b0;
        mem_wdata        = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    size_next    = s_tdata[SIZE_BITS-1:0];
                    granted_next = 1'b0;
                    if (!s_tuser) begin
                        idx_next   = '0;
                        state_next = ST_ADD_RD;
                    end else if (order_ok) begin
                        idx_next   = IDX_W'(in_order);
                        order_next = IDX_W'(in_order);
                        state_next = ST_SCAN_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ADD_RD: begin
                if (idx_reg == IDX_W'(NADD)) begin
                    state_next = ST_DONE;
                end else if (size_reg[0]) begin
                    state_next = ST_ADD_WR;
                end else begin
                    idx_next  = idx_reg + IDX_W'(1);
                    size_next = size_reg >> 1;
                end
            end
            ST_ADD_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = cnt_sat_inc(cnt);
                idx_next   = idx_reg + IDX_W'(1);
                size_next  = size_reg >> 1;
                state_next = ST_ADD_RD;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (cnt != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = cnt - CNT_W'(1);
                    if (idx_reg == order_reg) begin
                        granted_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_FILL;
                    end
                end else if (idx_reg == IDX_W'(LEVELS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FILL: begin
                // every order below the split block was empty: two halves
                // arrive, one moves on down, so one is left
                mem_we    = 1'b1;
                mem_wdata = CNT_W'(1);
                if (idx_reg == order_reg) begin
                    granted_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    grant_total_next = granted_reg ? cnt_sat_inc(grant_total_reg)
                                                   : grant_total_reg;
                    m_tvalid_next    = 1'b1;
                    m_tdata_next     = grant_total_next;
                    m_tuser_next     = granted_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            grant_total_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            grant_total_reg <= grant_total_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        order_reg   <= order_next;
        size_reg    <= size_next;
        granted_reg <= granted_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg  <= mem[mem_addr];
        rvalid_reg <= valid_reg[mem_addr];
    end

endmodule

[rtl/pba_checker.sv]
// Port-level checker for the power-of-two block allocator, bound to the top.
// Depends on pba_pkg.
module pba_checker
    import pba_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [CNT_W-1:0] m_tdata,
    input logic             m_tuser
);

    logic [CNT_W-1:0] last_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_total_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            last_total_reg <= m_tdata;
        end
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // total steps by one on a grant (unless saturated), else unchanged
    a_total_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata == cnt_sat_inc(last_total_reg)))
        else $error("grant total did not advance on a grant");

    a_total_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == last_total_reg))
        else $error("grant total moved without a grant");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind power_of_two_block_allocator pba_checker u_pba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/tb_top.sv]
// Self-checking bench for power_of_two_block_allocator: drives region and request words,
// predicts grants and running totals in a scoreboard class and checks every result word.
// Depends on rtl/pba_pkg.sv and rtl/power_of_two_block_allocator.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int LEVELS    = 40;
    localparam int SIZE_BITS = 34;
    localparam int S_DATA_W  = ((SIZE_BITS + ORDER_W + 7) / 8) * 8;

    typedef enum bit {
        KIND_REGION  = 1'b0,
        KIND_REQUEST = 1'b1
    } item_kind_e;

    typedef struct packed {
        logic             granted;
        logic [CNT_W-1:0] total;
    } grant_word_t;

    class alloc_tracker;
        logic [CNT_W-1:0] free_blocks [LEVELS];
        logic [CNT_W-1:0] grants;
        grant_word_t      pending [$];
        int               errors;

        function new();
            foreach (free_blocks[i]) free_blocks[i] = '0;
            grants = '0;
            errors = 0;
        endfunction

        function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
            return (a > CNT_MAX - b) ? CNT_MAX : a + b;
        endfunction

        // Accepted input word: update the free counts and queue the result it causes.
        function void take_word(item_kind_e kind, logic [SIZE_BITS-1:0] size,
                                logic [ORDER_W-1:0] order);
            grant_word_t  res;
            int unsigned  lvl;
            bit           ok;
            ok = 1'b0;
            if (kind == KIND_REGION) begin
                for (int j = 0; j < LEVELS && j < SIZE_BITS; j++) begin
                    if (size[j])
                        free_blocks[j] = sat_add(free_blocks[j], 1);
                end
            end else if (order < LEVELS) begin
                ok = 1'b1;
                if (free_blocks[order] == 0) begin
                    lvl = order + 1;
                    while (lvl < LEVELS && free_blocks[lvl] == 0)
                        lvl++;
                    if (lvl >= LEVELS) begin
                        ok = 1'b0;
                    end else begin
                        // split down, keeping one spare half per level
                        while (lvl > order) begin
                            free_blocks[lvl] = free_blocks[lvl] - 1;
                            free_blocks[lvl-1] = sat_add(free_blocks[lvl-1], 2);
                            lvl--;
                        end
                    end
                end
                if (ok) begin
                    free_blocks[order] = free_blocks[order] - 1;
                    grants = sat_add(grants, 1);
                end
            end
            res.granted = ok;
            res.total   = grants;
            pending = {pending, res};
        endfunction

        function void check_word(logic granted, logic [CNT_W-1:0] total);
            grant_word_t exp_word;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word: granted=%0b total=%0d",
                         $time, granted, total);
                errors++;
                return;
            end
            exp_word = pending.pop_front();
            if (granted !== exp_word.granted) begin
                $display("%0t: granted mismatch: expected %0b, actual %0b",
                         $time, exp_word.granted, granted);
                errors++;
            end
            if (total !== exp_word.total) begin
                $display("%0t: total_granted mismatch: expected %0d, actual %0d",
                         $time, exp_word.total, total);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CNT_W-1:0]    m_tdata;
    logic                m_tuser;

    int unsigned  tx_idle_pct  = 0;
    int unsigned  rx_stall_pct = 0;
    int unsigned  rx_hold_left = 0;
    bit           rx_hold_go   = 1'b0;
    bit           rx_hold_done = 1'b0;
    alloc_tracker tracker      = new();

    power_of_two_block_allocator #(
        .LEVELS    (LEVELS),
        .SIZE_BITS (SIZE_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: check on handshake, then pick next cycle's ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tuser, m_tdata);
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else if (rx_hold_go && !rx_hold_done) begin
            rx_hold_left <= 400;
            rx_hold_done <= 1'b1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    task automatic send_word(item_kind_e kind, logic [SIZE_BITS-1:0] size,
                             logic [ORDER_W-1:0] order);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99, 0) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({order, size});
        do @(posedge aclk); while (!s_tready);
        tracker.take_word(kind, size, order);
    endtask

    // Sender stops and waits for every outstanding result word.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_words(int n);
        logic [SIZE_BITS-1:0] size;
        logic [ORDER_W-1:0]   order;
        int unsigned          pick;
        for (int i = 0; i < n; i++) begin
            size  = SIZE_BITS'({$urandom_range(3, 0), $urandom});
            order = ORDER_W'($urandom_range(63, 0));
            if ($urandom_range(99, 0) < 25) begin
                pick = $urandom_range(2, 0);
                if (pick == 1)
                    size = SIZE_BITS'(1) << $urandom_range(SIZE_BITS - 1, 0);
                else if (pick == 2)
                    size = SIZE_BITS'($urandom_range(255, 0));
                send_word(KIND_REGION, size, order);
            end else begin
                pick = $urandom_range(99, 0);
                // mostly small orders so that the low levels run dry and splits occur
                if (pick < 70)
                    order = ORDER_W'($urandom_range(10, 0));
                else if (pick < 90)
                    order = ORDER_W'($urandom_range(SIZE_BITS - 1, 11));
                send_word(KIND_REQUEST, size, order);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pool, longest split, ignored size bits, out-of-range orders
        send_word(KIND_REQUEST, '0, ORDER_W'(5));
        send_word(KIND_REGION, '0, '0);
        send_word(KIND_REGION, SIZE_BITS'(1) << (SIZE_BITS - 1), '1);
        send_word(KIND_REQUEST, '0, ORDER_W'(0));
        send_word(KIND_REQUEST, '0, ORDER_W'(SIZE_BITS - 1));
        send_word(KIND_REGION, '1, '1);
        send_word(KIND_REQUEST, '1, ORDER_W'(SIZE_BITS - 1));
        send_word(KIND_REQUEST, '0, ORDER_W'(LEVELS - 1));
        send_word(KIND_REQUEST, '0, ORDER_W'(LEVELS));
        send_word(KIND_REQUEST, '1, '1);
        send_word(KIND_REQUEST, '0, ORDER_W'(SIZE_BITS));
        for (int k = 0; k < 6; k++)
            send_word(KIND_REQUEST, '0, ORDER_W'(k * 6));
        send_word(KIND_REGION, SIZE_BITS'(34'h2_AAAA_AAAA), '0);
        send_word(KIND_REGION, SIZE_BITS'(34'h1_5555_5555), '0);
        for (int k = 0; k < 4; k++)
            send_word(KIND_REQUEST, '0, ORDER_W'(0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
                default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
            endcase
            random_words(265);
            drain();
        end

        // long receiver hold while words keep coming: output fills, input backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_go   <= 1'b1;
        random_words(12);
        drain();

        repeat (200) @(posedge aclk);
        if (tracker.pending.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, tracker.pending.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/pba_pkg.sv
rtl/power_of_two_block_allocator.sv
rtl/pba_checker.sv
verif/tb_top.sv
